[design/bre_pkg.sv]
// Package: widths, action codes and defaults for the Exp-Golomb bit reader.
package bre_pkg;
	localparam int ACTION_W   = 3;
	localparam int LOAD_ADDR_W = 12;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 6;
	localparam int POS_W      = 16;
	localparam int SB_W       = 13;
	localparam int VALUE_W    = 32;

	localparam int BUFFER_BYTES_DEF  = 4096;
	localparam int MAX_READ_BITS_DEF = 32;

	localparam logic [ACTION_W-1:0] ACT_LOAD = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_GET  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_UE   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SE   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_SEEK = 3'd5;
endpackage

[design/bre_in_if.sv]
// Input channel interface: action beats into the bit reader.
interface bre_in_if;
	logic                              valid;
	logic                              ready;
	logic [bre_pkg::ACTION_W-1:0]      action;
	logic [bre_pkg::LOAD_ADDR_W-1:0]   load_address;
	logic [bre_pkg::BYTE_W-1:0]        load_byte;
	logic [bre_pkg::COUNT_W-1:0]       bit_count;
	logic [bre_pkg::POS_W-1:0]         seek_position;

	modport source (output valid, action, load_address, load_byte, bit_count, seek_position,
		input ready);
	modport sink (input valid, action, load_address, load_byte, bit_count, seek_position,
		output ready);
endinterface

[design/bre_out_if.sv]
// Output channel interface: result beats from the bit reader.
interface bre_out_if;
	logic                              valid;
	logic                              ready;
	logic [bre_pkg::VALUE_W-1:0]       unsigned_value;
	logic signed [bre_pkg::VALUE_W-1:0] signed_value;
	logic [bre_pkg::POS_W-1:0]         bits_remaining;
	logic                              at_end;
	logic                              code_error;

	modport source (output valid, unsigned_value, signed_value, bits_remaining, at_end,
		code_error, input ready);
	modport sink (input valid, unsigned_value, signed_value, bits_remaining, at_end,
		code_error, output ready);
endinterface

[design/bre_ram.sv]
// Generic simple dual-port RAM with registered read.
module bre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[design/bit_reader_exp_golomb.sv]
// Top level: Exp-Golomb bitstream reader over a byte buffer held in RAM.
// Load and seek beats give no result. A get or peek fetches five buffer bytes, one RAM
// read per cycle, then extracts the field. A ue or se beat runs that fetch twice, once
// for the zero-prefix scan and once for the suffix; an invalid code skips the suffix
// fetch. A single RAM read port serves every fetch. A result waits in the output
// register while the next beat is accepted. Bits past the stream length read as zero;
// no clearing pass follows reset.
module bit_reader_exp_golomb #(
	parameter int BUFFER_BYTES  = bre_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_READ_BITS = bre_pkg::MAX_READ_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [bre_pkg::SB_W-1:0] cfg_wr_data,
	bre_in_if.sink                   in_ch,
	bre_out_if.source                out_ch
);
	localparam int ADDR_W  = $clog2(BUFFER_BYTES);
	localparam int POS_W   = bre_pkg::POS_W;
	localparam int SB_W    = bre_pkg::SB_W;
	localparam int VW      = bre_pkg::VALUE_W;
	localparam int WIN_W   = 40;
	localparam int FP_W    = POS_W + 1;
	localparam int BI_W    = FP_W - 3 + 1;
	localparam int ADV_W   = 7;
	localparam int K_W     = 5;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;
	localparam logic [2:0] FETCH_BYTES = 3'd5;

	logic [2:0]                     state_q;
	logic [SB_W-1:0]                sb_q;
	logic [POS_W-1:0]               pos_q;
	logic [bre_pkg::ACTION_W-1:0]   act_q;
	logic [bre_pkg::COUNT_W-1:0]    cnt_bits_q;
	logic [FP_W-1:0]                fpos_q;
	logic [2:0]                     fcnt_q;
	logic                           rd_v_s1;
	logic                           rd_ok_s1;
	logic [WIN_W-1:0]               win_q;
	logic [VW-1:0]                  ext_q;
	logic                           second_q;
	logic [K_W-1:0]                 k_q;
	logic [VW-1:0]                  res_u_q;
	logic                           err_q;

	logic                           out_valid_q;
	logic [VW-1:0]                  out_u_q;
	logic [VW-1:0]                  out_s_q;
	logic [POS_W-1:0]               out_rem_q;
	logic                           out_end_q;
	logic                           out_err_q;

	logic [SB_W-1:0]                nbytes;
	logic [POS_W-1:0]               len;
	logic                           accept;
	logic                           is_ue;
	logic                           n_bad;
	logic [bre_pkg::COUNT_W-1:0]    nsel;
	logic [BI_W-1:0]                rd_idx;
	logic [ADDR_W-1:0]              raddr;
	logic [bre_pkg::BYTE_W-1:0]     rdata;
	logic                           ram_we;
	logic [ADDR_W-1:0]              waddr;
	logic [K_W-1:0]                 lz;
	logic [POS_W-1:0]               rem;
	logic [VW-1:0]                  sval;
	logic                           slot_free;

	function automatic logic [POS_W-1:0] adv(input logic [POS_W-1:0] p,
		input logic [POS_W-1:0] l, input logic [ADV_W-1:0] n);
		logic [FP_W-1:0] p2;
		p2 = {1'b0, p} + FP_W'(n);
		if (p2 > {1'b0, l})
			return (p > l) ? p : l;
		return p2[POS_W-1:0];
	endfunction

	function automatic logic [VW-1:0] extract(input logic [WIN_W-1:0] w,
		input logic [2:0] off, input logic [bre_pkg::COUNT_W-1:0] n);
		logic [WIN_W-1:0] sh;
		logic [VW-1:0]    top;
		sh  = w << off;
		top = sh[WIN_W-1 -: VW];
		return top >> (6'd32 - n);
	endfunction

	assign nbytes = (32'(sb_q) > BUFFER_BYTES) ? SB_W'(BUFFER_BYTES) : sb_q;
	assign len    = {nbytes, 3'b000};
	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign is_ue  = (act_q == bre_pkg::ACT_UE) || (act_q == bre_pkg::ACT_SE);
	assign n_bad  = 32'(cnt_bits_q) > MAX_READ_BITS;

	always_comb begin
		if (second_q)
			nsel = bre_pkg::COUNT_W'(k_q);
		else if (is_ue)
			nsel = 6'd32;
		else if (n_bad)
			nsel = '0;
		else
			nsel = cnt_bits_q;
	end

	assign rd_idx = BI_W'(fpos_q[FP_W-1:3]) + BI_W'(fcnt_q);
	assign raddr  = ADDR_W'(rd_idx);
	assign ram_we = accept && (in_ch.action == bre_pkg::ACT_LOAD);
	assign waddr  = ADDR_W'(in_ch.load_address % BUFFER_BYTES);

	bre_ram #(.WIDTH(bre_pkg::BYTE_W), .DEPTH(BUFFER_BYTES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (in_ch.load_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		lz = '0;
		for (int i = 0; i < VW; i++)
			if (ext_q[i])
				lz = K_W'(VW - 1 - i);
	end

	assign rem = (pos_q < len) ? len - pos_q : '0;
	assign slot_free = !out_valid_q || out_ch.ready;

	always_comb begin
		if (err_q || act_q != bre_pkg::ACT_SE)
			sval = '0;
		else if (res_u_q[0])
			sval = {1'b0, res_u_q[VW-1:1]} + 32'd1;
		else
			sval = 32'd0 - {1'b0, res_u_q[VW-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sb_q        <= '0;
			pos_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			fcnt_q      <= '0;
			second_q    <= 1'b0;
		end else begin
			if (cfg_wr_en)
				sb_q <= cfg_wr_data;
			if (out_valid_q && out_ch.ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			rd_v_s1 <= (state_q == ST_FETCH) && (fcnt_q < FETCH_BYTES);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q      <= in_ch.action;
						cnt_bits_q <= in_ch.bit_count;
						fpos_q     <= {1'b0, pos_q};
						fcnt_q     <= '0;
						second_q   <= 1'b0;
						err_q      <= 1'b0;
						case (in_ch.action) inside
							bre_pkg::ACT_SEEK:
								pos_q <= (in_ch.seek_position > len) ? len : in_ch.seek_position;
							bre_pkg::ACT_GET, bre_pkg::ACT_PEEK, bre_pkg::ACT_UE,
							bre_pkg::ACT_SE:
								state_q <= ST_FETCH;
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					if (fcnt_q < FETCH_BYTES) begin
						rd_ok_s1 <= rd_idx < BI_W'(nbytes);
						fcnt_q   <= fcnt_q + 3'd1;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					ext_q   <= extract(win_q, fpos_q[2:0], nsel);
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (!is_ue) begin
						res_u_q <= n_bad ? '0 : ext_q;
						if (act_q == bre_pkg::ACT_GET && !n_bad)
							pos_q <= adv(pos_q, len, ADV_W'(cnt_bits_q));
						state_q <= ST_DONE;
					end else if (!second_q) begin
						if (ext_q == '0) begin
							res_u_q <= '1;
							err_q   <= 1'b1;
							pos_q   <= adv(pos_q, len, ADV_W'(32));
							state_q <= ST_DONE;
						end else begin
							k_q      <= lz;
							fpos_q   <= {1'b0, pos_q} + FP_W'(lz) + FP_W'(1);
							fcnt_q   <= '0;
							second_q <= 1'b1;
							state_q  <= ST_FETCH;
						end
					end else begin
						res_u_q <= ((VW'(1) << k_q) - VW'(1)) + ext_q;
						pos_q   <= adv(pos_q, len, {1'b0, k_q, 1'b1});
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_u_q     <= res_u_q;
						out_s_q     <= sval;
						out_rem_q   <= rem;
						out_end_q   <= (rem == '0);
						out_err_q   <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1)
			win_q <= {win_q[WIN_W-9:0], rd_ok_s1 ? rdata : 8'h00};
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.unsigned_value = out_u_q;
	assign out_ch.signed_value   = out_s_q;
	assign out_ch.bits_remaining = out_rem_q;
	assign out_ch.at_end         = out_end_q;
	assign out_ch.code_error     = out_err_q;
endmodule
